### rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// shared types, constants and the millisecond to tick conversion
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned MsW    = 16;
  localparam int unsigned PrioW  = 3;
  localparam int unsigned TicksW = 13;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [MsW-1:0] TickRecip = 16'd52429;
  localparam int unsigned    TickShift = 19;
  localparam int unsigned    ProdW     = 2 * MsW;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } bps_op_e;

  typedef struct packed {
    logic [PrioW-1:0]  priority_req;
    logic [MsW-1:0]    off_ms;
    logic [MsW-1:0]    on_ms;
    logic [CountW-1:0] pulse_count;
    bps_op_e           op;
  } bps_cmd_t;

  typedef struct packed {
    logic active;
    logic buzzer_level;
  } bps_res_t;

  function automatic logic [TicksW-1:0] ms_to_ticks(input logic [MsW-1:0] ms);
    logic [ProdW-1:0] prod;
    prod = ProdW'(ms) * ProdW'(TickRecip);
    return prod[TickShift +: TicksW];
  endfunction

endpackage

### rtl/beep_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// beep_pattern_sequencer
// buzzer pulse pattern generator stepped by 10 ms tick transfers
// ----------------------------------------------------------------------------
// channel   dir  content
// s_axis    in   tuser = op (tick/start), tdata = pattern request
// m_axis    out  tdata = buzzer level and active flag, one per input transfer
//
// two register stages: input register, then state update into result register
// one transfer per cycle sustained while m_axis is ready
// the ms to tick conversion is a 16x16 reciprocal multiply in the update stage
// reset clears the pattern state and both stage valids, buzzer off
// a stalled m_axis holds the result; s_axis keeps flowing while a stage is free
// ----------------------------------------------------------------------------
module beep_pattern_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // pulse_count[7:0] on_ms[23:8] off_ms[39:24]
                                     // priority_req[42:40], zero pad
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // buzzer_level[0] active[1], zero pad
);

  bps_pkg::bps_cmd_t cmd_q, cmd_d;
  logic              in_valid_q;
  bps_pkg::bps_res_t res_q, res_d;
  logic              out_valid_q;
  logic              out_free;
  logic              step;
  logic              in_take;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign cmd_d.op           = bps_pkg::bps_op_e'(s_axis_tuser);
  assign cmd_d.pulse_count  = s_axis_tdata[7:0];
  assign cmd_d.on_ms        = s_axis_tdata[23:8];
  assign cmd_d.off_ms       = s_axis_tdata[39:24];
  assign cmd_d.priority_req = s_axis_tdata[42:40];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_d;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  bps_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .cmd_i   (cmd_q),
    .res_d_o (res_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, res_q.active, res_q.buzzer_level};

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(res_q)))
    else $error("result dropped or changed under stall");

  a_no_step_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> out_free)
    else $error("state stepped with result stage blocked");

  a_input_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> in_valid_q)
    else $error("pending input lost");

endmodule

### rtl/bps_core.sv
// ----------------------------------------------------------------------------
// bps_core
// pattern state and its one-step update for a tick or a start command
// ----------------------------------------------------------------------------
module bps_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bps_pkg::bps_cmd_t cmd_i,
  output bps_pkg::bps_res_t res_d_o
);

  logic [bps_pkg::TicksW-1:0] on_ticks_q, on_ticks_d;
  logic [bps_pkg::TicksW-1:0] off_ticks_q, off_ticks_d;
  logic [bps_pkg::TicksW-1:0] phase_q, phase_d;
  logic [bps_pkg::CountW-1:0] pulses_q, pulses_d;
  logic [bps_pkg::PrioW-1:0]  prio_q, prio_d;
  logic                       in_on_q, in_on_d;
  logic                       pin_q, pin_d;

  logic                       active;
  logic [bps_pkg::TicksW-1:0] on_t;
  logic [bps_pkg::TicksW-1:0] off_t;
  logic [bps_pkg::CountW-1:0] pulses_dec;

  assign active     = (pulses_q != '0);
  assign off_t      = bps_pkg::ms_to_ticks(cmd_i.off_ms);
  assign pulses_dec = pulses_q - bps_pkg::CountW'(1);

  always_comb begin
    on_t = bps_pkg::ms_to_ticks(cmd_i.on_ms);
    if (on_t == '0) begin
      on_t = bps_pkg::TicksW'(1);
    end
  end

  always_comb begin
    on_ticks_d  = on_ticks_q;
    off_ticks_d = off_ticks_q;
    phase_d     = phase_q;
    pulses_d    = pulses_q;
    prio_d      = prio_q;
    in_on_d     = in_on_q;
    pin_d       = pin_q;
    case (cmd_i.op)
      bps_pkg::OP_START: begin
        if (cmd_i.pulse_count != '0 && !(active && cmd_i.priority_req < prio_q)) begin
          on_ticks_d  = on_t;
          off_ticks_d = off_t;
          pulses_d    = cmd_i.pulse_count;
          prio_d      = cmd_i.priority_req;
          in_on_d     = 1'b1;
          phase_d     = on_t;
          pin_d       = 1'b1;
        end
      end
      bps_pkg::OP_TICK: begin
        if (active) begin
          if (phase_q != '0) begin
            phase_d = phase_q - bps_pkg::TicksW'(1);
          end else if (in_on_q) begin
            pin_d    = 1'b0;
            pulses_d = pulses_dec;
            if (pulses_dec != '0) begin
              if (off_ticks_q == '0) begin
                in_on_d = 1'b1;
                phase_d = on_ticks_q;
                pin_d   = 1'b1;
              end else begin
                in_on_d = 1'b0;
                phase_d = off_ticks_q;
              end
            end
          end else begin
            in_on_d = 1'b1;
            phase_d = on_ticks_q;
            pin_d   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_d_o.buzzer_level = pin_d;
  assign res_d_o.active       = (pulses_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_ticks_q  <= '0;
      off_ticks_q <= '0;
      phase_q     <= '0;
      pulses_q    <= '0;
      prio_q      <= '0;
      in_on_q     <= 1'b0;
      pin_q       <= 1'b0;
    end else if (step_i) begin
      on_ticks_q  <= on_ticks_d;
      off_ticks_q <= off_ticks_d;
      phase_q     <= phase_d;
      pulses_q    <= pulses_d;
      prio_q      <= prio_d;
      in_on_q     <= in_on_d;
      pin_q       <= pin_d;
    end
  end

  a_pin_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pin_q |-> active)
    else $error("buzzer on with no pattern");

  a_pin_follows_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active |-> (pin_q == in_on_q))
    else $error("buzzer level out of step with phase");

  a_on_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active |-> (on_ticks_q != '0))
    else $error("zero on time in a running pattern");

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active |-> (in_on_q ? (phase_q <= on_ticks_q) : (phase_q <= off_ticks_q)))
    else $error("phase counter beyond its load value");

endmodule
